// ===== sv/swkth_pkg.sv =====
// ----------------------------------------------------------------------------
// swkth_pkg: shared definitions for the sliding-window rank filter
// Default sizes, configuration register map and reset values.
// ----------------------------------------------------------------------------
package swkth_pkg;

  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Configuration port geometry.
  localparam int CFG_WIDTH       = 7;
  localparam int CFG_INDEX_WIDTH = 1;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_idx_t;
  typedef logic [CFG_WIDTH-1:0]       cfg_word_t;

  // Register indexes.
  localparam cfg_idx_t REG_WINDOW_SIZE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_RANK        = cfg_idx_t'(1);

  // Register reset values.
  localparam cfg_word_t WINDOW_SIZE_RESET = cfg_word_t'(64);
  localparam cfg_word_t RANK_RESET        = cfg_word_t'(1);

endpackage : swkth_pkg

// ===== sv/sliding_window_kth_smallest.sv =====
// ----------------------------------------------------------------------------
// sliding_window_kth_smallest: running rank-order filter
// Keeps the last window_size samples sorted in a row of cells and reports the
// rank-th smallest sample of every full window.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Direction  Moves
//  input     in_valid, in_ready, sample            in         one sample
//  output    out_valid, out_ready, ranked_value    out        one ranked value
//  config    cfg_write, cfg_index, cfg_data        in         one register write
//
//  Each accepted sample updates every cell of the sorted row in the same clock
//  edge, so the block takes one sample per cycle while in_ready is high.
//  A sample's result waits in the row until it moves into the output register;
//  a sample that does not yet fill the window produces no transaction.
//  Reset (synchronous, rst high) empties the window and sets window_size to
//  64 and rank to 1. Cell contents are not cleared; only filled cells are read.
//  While the output register holds an untaken result and another result waits
//  in the row, in_ready drops until out_ready frees the output register.
//
module sliding_window_kth_smallest #(
  parameter int MAX_WINDOW   = swkth_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = swkth_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] ranked_value,
  input  logic                           cfg_write,
  input  swkth_pkg::cfg_idx_t            cfg_index,
  input  swkth_pkg::cfg_word_t           cfg_data
);

  import swkth_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int EW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  // Configuration and control state.
  cfg_word_t       window_size;
  cfg_word_t       rank;
  logic [CW-1:0]   fill;
  logic            pend;

  // Effective window and rank.
  logic [EW-1:0]   ws_ext;
  logic [EW-1:0]   w_ext;
  logic [EW-1:0]   rk_ext;
  logic [EW-1:0]   r_ext;
  logic [CW-1:0]   w_cnt;
  logic [CW-1:0]   cnt_eff;
  logic [AW-1:0]   wm1;
  logic [AW-1:0]   sel_idx;
  logic            full;
  logic            last_fill;
  logic            move;
  logic            accept;

  // Cell row.
  logic signed [SAMPLE_WIDTH-1:0] cell_val [MAX_WINDOW];
  logic        [AW-1:0]           cell_age [MAX_WINDOW];
  logic        [MAX_WINDOW-1:0]   cell_lt;
  logic        [MAX_WINDOW-1:0]   cell_rm_seen;
  logic        [MAX_WINDOW-1:0]   cell_in_win;

  // A window size of zero counts as one; larger sizes saturate at the row length.
  assign ws_ext = EW'(window_size);
  always_comb begin
    if (ws_ext == '0) begin
      w_ext = EW'(1);
    end else if (ws_ext > EW'(MAX_WINDOW)) begin
      w_ext = EW'(MAX_WINDOW);
    end else begin
      w_ext = ws_ext;
    end
  end

  // Rank zero counts as one; rank is clamped to the window.
  assign rk_ext = EW'(rank);
  always_comb begin
    if (rk_ext == '0) begin
      r_ext = EW'(1);
    end else if (rk_ext > w_ext) begin
      r_ext = w_ext;
    end else begin
      r_ext = rk_ext;
    end
  end

  assign w_cnt     = CW'(w_ext);
  assign wm1       = AW'(w_cnt - CW'(1));
  assign sel_idx   = AW'(r_ext - EW'(1));
  assign full      = (fill >= w_cnt);
  assign last_fill = ((fill + CW'(1)) == w_cnt);
  assign cnt_eff   = full ? w_cnt : fill;

  // The row holds a result until it moves into the output register.
  assign move     = pend && (!out_valid || out_ready);
  assign in_ready = !pend || move;
  assign accept   = in_valid && in_ready;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] p_val;
    logic        [AW-1:0]           p_age;
    logic                           p_lt;
    logic                           p_rm;
    logic signed [SAMPLE_WIDTH-1:0] n_val;
    logic        [AW-1:0]           n_age;
    logic                           n_lt;

    assign cell_in_win[i] = (CW'(i) < cnt_eff);

    // The first cell sees an imaginary smaller neighbor, so the new sample
    // lands there when nothing in the window is below it.
    if (i == 0) begin : g_first
      assign p_val = '0;
      assign p_age = '0;
      assign p_lt  = 1'b1;
      assign p_rm  = 1'b0;
    end else begin : g_mid
      assign p_val = cell_val[i-1];
      assign p_age = cell_age[i-1];
      assign p_lt  = cell_lt[i-1];
      assign p_rm  = cell_rm_seen[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign n_val = '0;
      assign n_age = '0;
      assign n_lt  = 1'b0;
    end else begin : g_inner
      assign n_val = cell_val[i+1];
      assign n_age = cell_age[i+1];
      assign n_lt  = cell_lt[i+1];
    end

    swkth_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AW           (AW)
    ) u_cell (
      .clk          (clk),
      .upd          (accept),
      .key          (sample),
      .full         (full),
      .in_win       (cell_in_win[i]),
      .wm1          (wm1),
      .prev_val     (p_val),
      .prev_age     (p_age),
      .prev_lt      (p_lt),
      .prev_rm_seen (p_rm),
      .nxt_val      (n_val),
      .nxt_age      (n_age),
      .nxt_lt       (n_lt),
      .val          (cell_val[i]),
      .age          (cell_age[i]),
      .lt           (cell_lt[i]),
      .rm_seen      (cell_rm_seen[i])
    );
  end

  // Control registers. A window size write empties the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
      rank        <= RANK_RESET;
      fill        <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept && !full) begin
        fill <= fill + CW'(1);
      end
      if (accept) begin
        pend <= full || last_fill;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE: begin
            window_size <= cfg_data;
            fill        <= '0;
          end
          REG_RANK: begin
            rank <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      ranked_value <= cell_val[sel_idx];
    end
  end

  // The fill count never passes the window.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= w_cnt)
    else $error("fill count exceeds window size");

  // A full window always loses exactly its oldest sample on a new one.
  a_oldest_found: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |-> (cell_rm_seen[MAX_WINDOW-1] && $onehot(cell_rm_seen ^
      {cell_rm_seen[MAX_WINDOW-2:0], 1'b0})))
    else $error("oldest sample not found in sorted row");

  // Input stalls only behind two waiting results.
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (pend && out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // A sample that completes the window leaves a result in the row.
  a_result_pending: assert property (@(posedge clk) disable iff (rst)
    (accept && (full || last_fill) && !cfg_write) |=> pend)
    else $error("result of a full window was lost");

endmodule : sliding_window_kth_smallest

// ===== sv/swkth_cell.sv =====
// ----------------------------------------------------------------------------
// swkth_cell: one slot of the sorted window
// Holds one sample and its age, and takes its next content from itself or a
// neighbor so that the row stays sorted when a sample leaves and one enters.
// ----------------------------------------------------------------------------
module swkth_cell #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int AW           = 6
) (
  input  logic                           clk,
  input  logic                           upd,
  input  logic signed [SAMPLE_WIDTH-1:0] key,
  input  logic                           full,
  input  logic                           in_win,
  input  logic        [AW-1:0]           wm1,
  input  logic signed [SAMPLE_WIDTH-1:0] prev_val,
  input  logic        [AW-1:0]           prev_age,
  input  logic                           prev_lt,
  input  logic                           prev_rm_seen,
  input  logic signed [SAMPLE_WIDTH-1:0] nxt_val,
  input  logic        [AW-1:0]           nxt_age,
  input  logic                           nxt_lt,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic        [AW-1:0]           age,
  output logic                           lt,
  output logic                           rm_seen
);

  logic                           rm;
  logic signed [SAMPLE_WIDTH-1:0] r_val;
  logic        [AW-1:0]           r_age;
  logic                           r_lt;
  logic signed [SAMPLE_WIDTH-1:0] p_val;
  logic        [AW-1:0]           p_age;
  logic                           p_lt;
  logic signed [SAMPLE_WIDTH-1:0] val_next;
  logic        [AW-1:0]           age_next;

  // The oldest sample of a full window leaves; every slot at or after it
  // sees the remaining row shifted down by one.
  assign rm      = full && in_win && (age == wm1);
  assign rm_seen = prev_rm_seen | rm;
  assign lt      = in_win && (val < key);

  // Remaining row at this position and at the one before it.
  assign r_val = rm_seen ? nxt_val : val;
  assign r_age = rm_seen ? nxt_age : age;
  assign r_lt  = rm_seen ? nxt_lt  : lt;
  assign p_val = prev_rm_seen ? val : prev_val;
  assign p_age = prev_rm_seen ? age : prev_age;
  assign p_lt  = prev_rm_seen ? lt  : prev_lt;

  always_comb begin
    if (r_lt) begin
      val_next = r_val;
      age_next = r_age + AW'(1);
    end else if (p_lt) begin
      val_next = key;
      age_next = '0;
    end else begin
      val_next = p_val;
      age_next = p_age + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule : swkth_cell

// ===== verif/rank_filter_checker.sv =====
// ----------------------------------------------------------------------------
// rank_filter_checker: prediction and comparison for the rank filter
// Watches the configuration port and both streaming channels, keeps its own
// image of the window, and compares every ranked value leaving the block with
// the value its own window gives.
// ----------------------------------------------------------------------------
module rank_filter_checker #(
  parameter int MAX_WINDOW   = swkth_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = swkth_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] ranked_value,
  input  logic                           cfg_write,
  input  swkth_pkg::cfg_idx_t            cfg_index,
  input  swkth_pkg::cfg_word_t           cfg_data,
  output int                             mismatches,
  output int                             backlog
);

  // Window image: arrival order and ascending order.
  logic signed [SAMPLE_WIDTH-1:0] ring    [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] ordered [MAX_WINDOW];
  int                             head;
  int                             filled;
  swkth_pkg::cfg_word_t           win_reg;
  swkth_pkg::cfg_word_t           rank_reg;

  // Ranked values still owed by the block, oldest first, kept in a small ring.
  localparam int DUE_DEPTH = 16;
  logic signed [SAMPLE_WIDTH-1:0] due_ranks [DUE_DEPTH];
  int                             due_rd;
  int                             due_wr;
  int                             due_cnt;

  function automatic int clamp_span(int v, int hi);
    if (v < 1) v = 1;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Bubble the entry at position p into place within ordered[0..n-1].
  function automatic void settle_entry(int p, int n);
    logic signed [SAMPLE_WIDTH-1:0] t;
    while (p > 0 && ordered[p] < ordered[p-1]) begin
      t            = ordered[p-1];
      ordered[p-1] = ordered[p];
      ordered[p]   = t;
      p--;
    end
    while (p + 1 < n && ordered[p] > ordered[p+1]) begin
      t            = ordered[p+1];
      ordered[p+1] = ordered[p];
      ordered[p]   = t;
      p++;
    end
  endfunction

  // Take one sample into the window; made is set when the window is full.
  function automatic void absorb_sample(input logic signed [SAMPLE_WIDTH-1:0] s,
                                        output bit made,
                                        output logic signed [SAMPLE_WIDTH-1:0] value);
    int w;
    int pos;
    logic signed [SAMPLE_WIDTH-1:0] old;
    bit found;
    w     = clamp_span(int'(win_reg), MAX_WINDOW);
    made  = 1'b0;
    value = '0;
    if (filled > w) filled = w;
    if (head >= w) head = 0;
    if (filled < w) begin
      ring[filled]    = s;
      ordered[filled] = s;
      settle_entry(filled, filled + 1);
      filled++;
    end else begin
      // The oldest sample leaves; the new one takes its slot and moves.
      old   = ring[head];
      pos   = w - 1;
      found = 1'b0;
      for (int i = 0; i < w; i++) begin
        if (!found && ordered[i] == old) begin
          pos   = i;
          found = 1'b1;
        end
      end
      ordered[pos] = s;
      settle_entry(pos, w);
      ring[head] = s;
      head = (head + 1 == w) ? 0 : head + 1;
    end
    if (filled >= w) begin
      made  = 1'b1;
      value = ordered[clamp_span(int'(rank_reg), w) - 1];
    end
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    logic signed [SAMPLE_WIDTH-1:0] want;
    bit made;
    if (rst) begin
      win_reg    = swkth_pkg::WINDOW_SIZE_RESET;
      rank_reg   = swkth_pkg::RANK_RESET;
      head       = 0;
      filled     = 0;
      mismatches = 0;
      due_rd     = 0;
      due_wr     = 0;
      due_cnt    = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == swkth_pkg::REG_WINDOW_SIZE) begin
          win_reg = cfg_data;
          filled  = 0;
          head    = 0;
        end else if (cfg_index == swkth_pkg::REG_RANK) begin
          rank_reg = cfg_data;
        end
      end
      // The result leaving now belongs to an earlier sample, so compare first.
      if (out_valid && out_ready) begin
        if (due_cnt == 0) begin
          flag_mismatch($sformatf("ranked_value %0d with nothing expected", ranked_value));
        end else begin
          want    = due_ranks[due_rd];
          due_rd  = (due_rd + 1) % DUE_DEPTH;
          due_cnt--;
          if (ranked_value !== want)
            flag_mismatch($sformatf("ranked_value %0d, expected %0d", ranked_value, want));
        end
      end
      if (in_valid && in_ready) begin
        absorb_sample(sample, made, want);
        if (made) begin
          if (due_cnt == DUE_DEPTH) begin
            flag_mismatch("more ranked values owed than the block can hold");
          end else begin
            due_ranks[due_wr] = want;
            due_wr            = (due_wr + 1) % DUE_DEPTH;
            due_cnt++;
          end
        end
      end
    end
    backlog <= due_cnt;
  end

endmodule : rank_filter_checker

// ===== verif/sliding_window_kth_smallest_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_kth_smallest_tb: regression for the sliding-window rank filter
// Drives corner samples and then long random phases under many window and
// rank settings, with random stalls on both channels, and lets the checker
// compare every ranked value against its own window.
// ----------------------------------------------------------------------------
module sliding_window_kth_smallest_tb;

  import swkth_pkg::*;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int TOTAL_ITEMS  = 1320;   // directed plus random samples
  localparam int QUIET_TAIL   = 150;    // samples at the end with no idling
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int DRAIN_CYCLES = 4;      // result copy-out latency plus margin
  localparam int LIMIT_CYCLES = 400000;

  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic signed [SW-1:0] sample;
  logic              out_valid;
  logic              out_ready;
  logic signed [SW-1:0] ranked_value;
  logic              cfg_write;
  cfg_idx_t          cfg_index;
  cfg_word_t         cfg_data;

  int mismatches;
  int backlog;

  // Stimulus controls. The receiver reads hold_rx and quiet_rx at the clock
  // edge, so they are changed with nonblocking assignments only.
  logic hold_rx;
  logic quiet_rx;
  bit   quiet_tx;
  int   items_sent;

  sliding_window_kth_smallest dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ranked_value (ranked_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rank_filter_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ranked_value (ranked_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .backlog      (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a healthy run ends far earlier than this.
  initial begin
    #(LIMIT_CYCLES * 4);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver side. It alternates ready stretches with idle bursts, honors one
  // long hold-off on request, and stays ready once the quiet tail begins.
  // The hold request is cleared as the hold starts so that it is seen once.
  initial begin : rx_side
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        hold_rx   <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_rx && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // Sender idle burst: valid is dropped while the task waits.
  task automatic pause_tx(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one sample and hold it until the block takes the transaction.
  // Valid is not lowered here, so back-to-back samples keep it high.
  task automatic feed(input logic signed [SW-1:0] v);
    if (!quiet_tx && $urandom_range(0, 3) == 0) pause_tx($urandom_range(1, 17));
    in_valid <= 1'b1;
    sample   <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending and wait until every owed ranked value has left the block,
  // then give a sample that owes nothing time to finish inside the row.
  // The first edge lets the checker's backlog catch up with the last sample.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write on the plain write port; always lowers the enable again so
  // that a following write never toggles the enable within one time step.
  task automatic write_register(input cfg_idx_t idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cfg_word_t'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of full-range values, a narrow band that produces many duplicates,
  // and the corner values of the sample field.
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return '0;
          3:       return '1;
          default: return SW'(1);
        endcase
      end
      1, 2, 3: return SW'($signed($urandom_range(0, 15)) - 8);
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int win;
    int eff;
    int rnk;
    int n;

    in_valid   = 1'b0;
    sample     = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_WINDOW_SIZE;
    cfg_data   = '0;
    hold_rx    = 1'b0;
    quiet_rx   = 1'b0;
    quiet_tx   = 1'b0;
    items_sent = 0;
    rst        = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A window of four, second smallest: extremes of the
    // sample field, duplicates, and the oldest sample leaving while equal
    // values sit beside it in the sorted row.
    write_register(REG_WINDOW_SIZE, 4);
    write_register(REG_RANK, 2);
    feed(S_MIN); feed(S_MAX); feed('0);   feed('1);
    feed(SW'(1)); feed(S_MAX); feed(S_MAX); feed(S_MIN);
    feed(S_MIN); feed(SW'(5)); feed(SW'(5)); feed(SW'(5));
    drain_results();

    // A window size of zero acts as one and a rank of zero as the minimum:
    // every sample reports itself.
    write_register(REG_WINDOW_SIZE, 0);
    write_register(REG_RANK, 0);
    feed(SW'(7)); feed(S_MIN); feed(S_MAX);
    drain_results();

    // A rank above the window size reports the window maximum.
    write_register(REG_WINDOW_SIZE, 3);
    write_register(REG_RANK, 100);
    feed(-SW'(5)); feed(SW'(9)); feed(SW'(2)); feed(S_MIN); feed(SW'(4));
    drain_results();

    // A rank write alone keeps the full window, so results continue at once.
    write_register(REG_RANK, 1);
    feed(SW'(10)); feed(-SW'(10));

    // Random part: one configuration per phase. The first phases pin the
    // settings that matter most: window above the maximum, the full window
    // with the rank clamped, the back-pressure phase, and the smallest sizes.
    phase = 0;
    win   = 3;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - QUIET_TAIL) begin
        quiet_tx = 1'b1;
        quiet_rx <= 1'b1;
      end
      drain_results();

      case (phase)
        0: begin win = 127; rnk = 64;  end
        1: begin win = 64;  rnk = 127; end
        2: begin win = 8;   rnk = 4;   end
        3: begin win = 0;   rnk = 5;   end
        4: begin win = 1;   rnk = 1;   end
        5: begin win = 2;   rnk = 2;   end
        6: begin win = 65;  rnk = 0;   end
        default: begin
          if ($urandom_range(0, 3) == 0) win = $urandom_range(0, 127);
          else win = $urandom_range(1, 12);
          rnk = 0;
        end
      endcase
      eff = (win < 1) ? 1 : (win > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win;

      if (phase > 6) begin
        case ($urandom_range(0, 4))
          0:       rnk = 0;
          1:       rnk = 127;
          2:       rnk = eff;
          default: rnk = $urandom_range(1, eff);
        endcase
      end

      // Some later phases change only the rank, so the filled window is kept
      // and the previous window size stays in force.
      if (phase > 6 && $urandom_range(0, 3) == 0) begin
        write_register(REG_RANK, rnk);
        n = $urandom_range(3, 40);
      end else begin
        write_register(REG_WINDOW_SIZE, win);
        write_register(REG_RANK, rnk);
        n = eff + $urandom_range(3, 40);
      end

      if (phase == 2) begin
        // Back-pressure phase: the receiver holds off for a long stretch
        // while samples keep coming with no gaps, so the output register and
        // the row both fill and the block must drop in_ready.
        hold_rx <= 1'b1;
        quiet_tx = 1'b1;
        n = 80;
      end

      // The quiet tail is one unbroken phase that sends every remaining sample.
      if (quiet_tx && phase != 2) n = TOTAL_ITEMS - items_sent;

      repeat (n) feed(pick_sample());
      if (phase == 2) quiet_tx = 1'b0;
      phase++;
    end

    drain_results();
    if (mismatches == 0 && backlog == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : sliding_window_kth_smallest_tb

// ===== sliding_window_kth_smallest.f =====
sv/swkth_pkg.sv
sv/swkth_cell.sv
sv/sliding_window_kth_smallest.sv
verif/rank_filter_checker.sv
verif/sliding_window_kth_smallest_tb.sv
